// ----- hw/rtl/mh64v1_pkg.sv -----
// Shared types, constants and micro-program for the MetroHash64 variant 1 engine.
`default_nettype none
package mh64v1_pkg;

    localparam logic [31:0] K0 = 32'hC83A91E1;
    localparam logic [31:0] K1 = 32'h8648DBDB;
    localparam logic [31:0] K2 = 32'h7BDEC03B;
    localparam logic [31:0] K3 = 32'h2F5870A5;
    localparam logic [31:0] SEED_RESET = 32'd233;

    localparam int NSEG = 9;
    localparam int PC_W = 7;

    localparam logic [3:0] SEG_INIT = 4'd0;
    localparam logic [3:0] SEG_LANE = 4'd1;
    localparam logic [3:0] SEG_FOLD = 4'd2;
    localparam logic [3:0] SEG_T2   = 4'd3;
    localparam logic [3:0] SEG_T1   = 4'd4;
    localparam logic [3:0] SEG_P4   = 4'd5;
    localparam logic [3:0] SEG_P2   = 4'd6;
    localparam logic [3:0] SEG_P1   = 4'd7;
    localparam logic [3:0] SEG_FIN  = 4'd8;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_XOR = 2'd1,
        OP_SHR = 2'd2,
        OP_MUL = 2'd3
    } t_op;

    typedef enum logic [4:0] {
        R_V0   = 5'd0,
        R_V1   = 5'd1,
        R_V2   = 5'd2,
        R_V3   = 5'd3,
        R_H    = 5'd4,
        R_A    = 5'd5,
        R_B    = 5'd6,
        R_T    = 5'd7,
        R_DATA = 5'd8,
        R_W0   = 5'd9,
        R_W1   = 5'd10,
        R_W2   = 5'd11,
        R_WT1  = 5'd12,
        R_SEED = 5'd13,
        R_LEN  = 5'd14,
        R_KC   = 5'd15,
        R_ZERO = 5'd16,
        R_P32  = 5'd17,
        R_P16  = 5'd18,
        R_P8   = 5'd19
    } t_reg;

    typedef struct packed {
        t_op        op;
        t_reg       dst;
        t_reg       sa;
        t_reg       sb;
        logic [5:0] rot;
        logic [1:0] k;
        logic       fin;
    } t_uop;

    function automatic logic [31:0] kconst(input logic [1:0] k);
        case (k)
            2'd0:    kconst = K0;
            2'd1:    kconst = K1;
            2'd2:    kconst = K2;
            default: kconst = K3;
        endcase
    endfunction

    function automatic t_uop mk(input t_op op, input t_reg dst, input t_reg sa,
                                input t_reg sb, input logic [5:0] rot,
                                input logic [1:0] k, input logic fin);
        t_uop u;
        u.op  = op;
        u.dst = dst;
        u.sa  = sa;
        u.sb  = sb;
        u.rot = rot;
        u.k   = k;
        u.fin = fin;
        return u;
    endfunction

    function automatic logic [PC_W-1:0] seg_start(input logic [3:0] seg);
        case (seg)
            SEG_INIT: seg_start = 7'd0;
            SEG_LANE: seg_start = 7'd7;
            SEG_FOLD: seg_start = 7'd19;
            SEG_T2:   seg_start = 7'd41;
            SEG_T1:   seg_start = 7'd54;
            SEG_P4:   seg_start = 7'd58;
            SEG_P2:   seg_start = 7'd63;
            SEG_P1:   seg_start = 7'd68;
            SEG_FIN:  seg_start = 7'd72;
            default:  seg_start = 7'd72;
        endcase
    endfunction

    function automatic logic [3:0] first_seg(input logic [NSEG-1:0] mask);
        logic [3:0] idx;
        idx = SEG_FIN;
        for (int i = NSEG - 1; i >= 0; i--) begin
            if (mask[i]) begin
                idx = 4'(i);
            end
        end
        return idx;
    endfunction

    function automatic t_uop uop(input logic [PC_W-1:0] pc);
        case (pc)
            7'd0:  uop = mk(OP_ADD, R_T,  R_SEED, R_KC,   6'd0,  2'd2, 1'b0);
            7'd1:  uop = mk(OP_MUL, R_T,  R_T,    R_ZERO, 6'd0,  2'd0, 1'b0);
            7'd2:  uop = mk(OP_ADD, R_H,  R_T,    R_LEN,  6'd0,  2'd0, 1'b0);
            7'd3:  uop = mk(OP_ADD, R_V0, R_H,    R_ZERO, 6'd0,  2'd0, 1'b0);
            7'd4:  uop = mk(OP_ADD, R_V1, R_H,    R_ZERO, 6'd0,  2'd0, 1'b0);
            7'd5:  uop = mk(OP_ADD, R_V2, R_H,    R_ZERO, 6'd0,  2'd0, 1'b0);
            7'd6:  uop = mk(OP_ADD, R_V3, R_H,    R_ZERO, 6'd0,  2'd0, 1'b1);
            7'd7:  uop = mk(OP_MUL, R_T,  R_W0,   R_ZERO, 6'd0,  2'd0, 1'b0);
            7'd8:  uop = mk(OP_ADD, R_V0, R_V0,   R_T,    6'd0,  2'd0, 1'b0);
            7'd9:  uop = mk(OP_ADD, R_V0, R_V0,   R_V2,   6'd29, 2'd0, 1'b0);
            7'd10: uop = mk(OP_MUL, R_T,  R_W1,   R_ZERO, 6'd0,  2'd1, 1'b0);
            7'd11: uop = mk(OP_ADD, R_V1, R_V1,   R_T,    6'd0,  2'd0, 1'b0);
            7'd12: uop = mk(OP_ADD, R_V1, R_V1,   R_V3,   6'd29, 2'd0, 1'b0);
            7'd13: uop = mk(OP_MUL, R_T,  R_W2,   R_ZERO, 6'd0,  2'd2, 1'b0);
            7'd14: uop = mk(OP_ADD, R_V2, R_V2,   R_T,    6'd0,  2'd0, 1'b0);
            7'd15: uop = mk(OP_ADD, R_V2, R_V2,   R_V0,   6'd29, 2'd0, 1'b0);
            7'd16: uop = mk(OP_MUL, R_T,  R_DATA, R_ZERO, 6'd0,  2'd3, 1'b0);
            7'd17: uop = mk(OP_ADD, R_V3, R_V3,   R_T,    6'd0,  2'd0, 1'b0);
            7'd18: uop = mk(OP_ADD, R_V3, R_V3,   R_V1,   6'd29, 2'd0, 1'b1);
            7'd19: uop = mk(OP_ADD, R_T,  R_V0,   R_V3,   6'd0,  2'd0, 1'b0);
            7'd20: uop = mk(OP_MUL, R_T,  R_T,    R_ZERO, 6'd0,  2'd0, 1'b0);
            7'd21: uop = mk(OP_ADD, R_T,  R_T,    R_V1,   6'd0,  2'd0, 1'b0);
            7'd22: uop = mk(OP_MUL, R_T,  R_T,    R_ZERO, 6'd33, 2'd1, 1'b0);
            7'd23: uop = mk(OP_XOR, R_V2, R_V2,   R_T,    6'd0,  2'd0, 1'b0);
            7'd24: uop = mk(OP_ADD, R_T,  R_V1,   R_V2,   6'd0,  2'd0, 1'b0);
            7'd25: uop = mk(OP_MUL, R_T,  R_T,    R_ZERO, 6'd0,  2'd1, 1'b0);
            7'd26: uop = mk(OP_ADD, R_T,  R_T,    R_V0,   6'd0,  2'd0, 1'b0);
            7'd27: uop = mk(OP_MUL, R_T,  R_T,    R_ZERO, 6'd33, 2'd0, 1'b0);
            7'd28: uop = mk(OP_XOR, R_V3, R_V3,   R_T,    6'd0,  2'd0, 1'b0);
            7'd29: uop = mk(OP_ADD, R_T,  R_V0,   R_V2,   6'd0,  2'd0, 1'b0);
            7'd30: uop = mk(OP_MUL, R_T,  R_T,    R_ZERO, 6'd0,  2'd0, 1'b0);
            7'd31: uop = mk(OP_ADD, R_T,  R_T,    R_V3,   6'd0,  2'd0, 1'b0);
            7'd32: uop = mk(OP_MUL, R_T,  R_T,    R_ZERO, 6'd33, 2'd1, 1'b0);
            7'd33: uop = mk(OP_XOR, R_V0, R_V0,   R_T,    6'd0,  2'd0, 1'b0);
            7'd34: uop = mk(OP_ADD, R_T,  R_V1,   R_V3,   6'd0,  2'd0, 1'b0);
            7'd35: uop = mk(OP_MUL, R_T,  R_T,    R_ZERO, 6'd0,  2'd1, 1'b0);
            7'd36: uop = mk(OP_ADD, R_T,  R_T,    R_V2,   6'd0,  2'd0, 1'b0);
            7'd37: uop = mk(OP_MUL, R_T,  R_T,    R_ZERO, 6'd33, 2'd0, 1'b0);
            7'd38: uop = mk(OP_XOR, R_V1, R_V1,   R_T,    6'd0,  2'd0, 1'b0);
            7'd39: uop = mk(OP_XOR, R_T,  R_V0,   R_V1,   6'd0,  2'd0, 1'b0);
            7'd40: uop = mk(OP_ADD, R_H,  R_H,    R_T,    6'd0,  2'd0, 1'b1);
            7'd41: uop = mk(OP_MUL, R_A,  R_W0,   R_ZERO, 6'd0,  2'd0, 1'b0);
            7'd42: uop = mk(OP_ADD, R_A,  R_A,    R_H,    6'd0,  2'd0, 1'b0);
            7'd43: uop = mk(OP_MUL, R_A,  R_A,    R_ZERO, 6'd33, 2'd1, 1'b0);
            7'd44: uop = mk(OP_MUL, R_B,  R_W1,   R_ZERO, 6'd0,  2'd1, 1'b0);
            7'd45: uop = mk(OP_ADD, R_B,  R_B,    R_H,    6'd0,  2'd0, 1'b0);
            7'd46: uop = mk(OP_MUL, R_B,  R_B,    R_ZERO, 6'd33, 2'd2, 1'b0);
            7'd47: uop = mk(OP_MUL, R_T,  R_A,    R_ZERO, 6'd0,  2'd0, 1'b0);
            7'd48: uop = mk(OP_ADD, R_T,  R_T,    R_B,    6'd35, 2'd0, 1'b0);
            7'd49: uop = mk(OP_XOR, R_A,  R_A,    R_T,    6'd0,  2'd0, 1'b0);
            7'd50: uop = mk(OP_MUL, R_T,  R_B,    R_ZERO, 6'd0,  2'd3, 1'b0);
            7'd51: uop = mk(OP_ADD, R_T,  R_T,    R_A,    6'd35, 2'd0, 1'b0);
            7'd52: uop = mk(OP_XOR, R_B,  R_B,    R_T,    6'd0,  2'd0, 1'b0);
            7'd53: uop = mk(OP_ADD, R_H,  R_H,    R_B,    6'd0,  2'd0, 1'b1);
            7'd54: uop = mk(OP_MUL, R_T,  R_WT1,  R_ZERO, 6'd0,  2'd3, 1'b0);
            7'd55: uop = mk(OP_ADD, R_H,  R_H,    R_T,    6'd0,  2'd0, 1'b0);
            7'd56: uop = mk(OP_MUL, R_T,  R_H,    R_ZERO, 6'd33, 2'd1, 1'b0);
            7'd57: uop = mk(OP_XOR, R_H,  R_H,    R_T,    6'd0,  2'd0, 1'b1);
            7'd58: uop = mk(OP_MUL, R_T,  R_P32,  R_ZERO, 6'd0,  2'd3, 1'b0);
            7'd59: uop = mk(OP_ADD, R_H,  R_H,    R_T,    6'd0,  2'd0, 1'b0);
            7'd60: uop = mk(OP_MUL, R_T,  R_H,    R_ZERO, 6'd15, 2'd1, 1'b0);
            7'd61: uop = mk(OP_XOR, R_H,  R_H,    R_T,    6'd0,  2'd0, 1'b0);
            7'd62: uop = mk(OP_SHR, R_DATA, R_DATA, R_ZERO, 6'd32, 2'd0, 1'b1);
            7'd63: uop = mk(OP_MUL, R_T,  R_P16,  R_ZERO, 6'd0,  2'd3, 1'b0);
            7'd64: uop = mk(OP_ADD, R_H,  R_H,    R_T,    6'd0,  2'd0, 1'b0);
            7'd65: uop = mk(OP_MUL, R_T,  R_H,    R_ZERO, 6'd13, 2'd1, 1'b0);
            7'd66: uop = mk(OP_XOR, R_H,  R_H,    R_T,    6'd0,  2'd0, 1'b0);
            7'd67: uop = mk(OP_SHR, R_DATA, R_DATA, R_ZERO, 6'd16, 2'd0, 1'b1);
            7'd68: uop = mk(OP_MUL, R_T,  R_P8,   R_ZERO, 6'd0,  2'd3, 1'b0);
            7'd69: uop = mk(OP_ADD, R_H,  R_H,    R_T,    6'd0,  2'd0, 1'b0);
            7'd70: uop = mk(OP_MUL, R_T,  R_H,    R_ZERO, 6'd25, 2'd1, 1'b0);
            7'd71: uop = mk(OP_XOR, R_H,  R_H,    R_T,    6'd0,  2'd0, 1'b1);
            7'd72: uop = mk(OP_XOR, R_H,  R_H,    R_H,    6'd33, 2'd0, 1'b0);
            7'd73: uop = mk(OP_MUL, R_H,  R_H,    R_ZERO, 6'd0,  2'd0, 1'b0);
            7'd74: uop = mk(OP_XOR, R_H,  R_H,    R_H,    6'd33, 2'd0, 1'b1);
            default: uop = mk(OP_XOR, R_H, R_H,   R_H,    6'd33, 2'd0, 1'b1);
        endcase
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/mh64v1_alu.sv -----
// Shared rotate / add / xor / shift / two-pass 64x32 multiply unit.
`default_nettype none
module mh64v1_alu (
    input  wire logic             i_clk,
    input  wire mh64v1_pkg::t_uop i_uop,
    input  wire logic             i_mul_hi,
    input  wire logic [63:0]      i_a,
    input  wire logic [63:0]      i_b,
    output logic [63:0]           o_res
);
    logic [127:0] dbl;
    logic [63:0]  ra;
    logic [31:0]  mop;
    logic [63:0]  prod;
    logic [63:0]  r_prod;

    assign dbl  = {i_a, i_a} >> i_uop.rot;
    assign ra   = dbl[63:0];
    assign mop  = i_mul_hi ? ra[63:32] : ra[31:0];
    assign prod = mop * mh64v1_pkg::kconst(i_uop.k);

    always_ff @(posedge i_clk) begin
        if (!i_mul_hi) begin
            r_prod <= prod;
        end
    end

    always_comb begin
        case (i_uop.op)
            mh64v1_pkg::OP_ADD: o_res = ra + i_b;
            mh64v1_pkg::OP_XOR: o_res = ra ^ i_b;
            mh64v1_pkg::OP_SHR: o_res = i_a >> i_uop.rot;
            mh64v1_pkg::OP_MUL: o_res = r_prod + {prod[31:0], 32'd0};
            default:            o_res = ra;
        endcase
    end
endmodule
`default_nettype wire

// ----- hw/rtl/metrohash64_variant1_top.sv -----
// Top level of the MetroHash64 variant 1 streaming hash engine.
// Message words enter on the slave stream, one request at a time; the block is busy while
// a micro-program runs on one shared 64-bit unit (rotate, add, xor, shift and a 32x32
// multiplier used twice per 64x32 product). A non-last word that only fills the buffer
// runs no steps; the first word of a message adds seeding steps; the word that completes
// a 32-byte group runs the lane steps; the last word runs the fold and tail steps it needs
// and the final mix, then the output register is loaded once it is free. The hash leaves
// through that register, so the next message may start while it waits.
`default_nettype none
module metrohash64_variant1_top (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_wr_en,
    input  wire logic [31:0]   i_cfg_wr_data,
    input  wire logic          i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    // [63:0] data_word, [67:64] byte_count, [131:68] message_length, [135:132] zero
    input  wire logic [135:0]  i_s_axis_tdata,
    input  wire logic          i_s_axis_tlast,
    output logic               o_m_axis_tvalid,
    input  wire logic          i_m_axis_tready,
    // [63:0] hash_value
    output logic [63:0]        o_m_axis_tdata
);
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic [31:0] r_seed;
    logic [63:0] r_v0, r_v1, r_v2, r_v3, r_h, r_a, r_b, r_t, r_data, r_len;
    logic [63:0] r_w0, r_w1, r_w2;
    logic [1:0]  r_bcnt, n_bcnt;
    logic        r_bs, n_bs;
    logic        r_start;
    logic        r_wt1_sel;
    logic        r_last;
    logic [mh64v1_pkg::NSEG-1:0]  r_mask, n_mask;
    logic [mh64v1_pkg::PC_W-1:0]  r_pc;
    logic        r_mul_hi;
    logic        r_ovalid;
    logic [63:0] r_odata;

    logic        acc;
    logic [63:0] in_data, in_len;
    logic [3:0]  in_bc, bc_c;
    logic        full, lane;
    logic [1:0]  bc_eff, n_cnt;
    logic        bs_eff;
    mh64v1_pkg::t_uop cur;
    logic [63:0] op_a, op_b, res;
    logic        step_done;
    logic [mh64v1_pkg::NSEG-1:0] rest;
    logic        out_free;

    assign acc     = i_s_axis_tvalid && o_s_axis_tready;
    assign in_data = i_s_axis_tdata[63:0];
    assign in_bc   = i_s_axis_tdata[67:64];
    assign in_len  = i_s_axis_tdata[131:68];
    assign bc_c    = (in_bc > 4'd8) ? 4'd8 : in_bc;
    assign full    = !i_s_axis_tlast || (bc_c == 4'd8);
    assign bc_eff  = r_start ? 2'd0 : r_bcnt;
    assign bs_eff  = r_start ? 1'b0 : r_bs;
    assign lane    = full && (bc_eff == 2'd3);
    assign n_cnt   = lane ? 2'd0 : (full ? bc_eff + 2'd1 : bc_eff);

    always_comb begin
        n_mask = '0;
        n_mask[mh64v1_pkg::SEG_INIT] = r_start;
        n_mask[mh64v1_pkg::SEG_LANE] = lane;
        n_mask[mh64v1_pkg::SEG_FOLD] = i_s_axis_tlast && (bs_eff || lane);
        n_mask[mh64v1_pkg::SEG_T2]   = i_s_axis_tlast && n_cnt[1];
        n_mask[mh64v1_pkg::SEG_T1]   = i_s_axis_tlast && n_cnt[0];
        n_mask[mh64v1_pkg::SEG_P4]   = i_s_axis_tlast && !full && bc_c[2];
        n_mask[mh64v1_pkg::SEG_P2]   = i_s_axis_tlast && !full && bc_c[1];
        n_mask[mh64v1_pkg::SEG_P1]   = i_s_axis_tlast && !full && bc_c[0];
        n_mask[mh64v1_pkg::SEG_FIN]  = i_s_axis_tlast;
        n_bcnt = n_cnt;
        n_bs   = bs_eff || lane;
    end

    assign cur       = mh64v1_pkg::uop(r_pc);
    assign step_done = (cur.op != mh64v1_pkg::OP_MUL) || r_mul_hi;
    assign rest      = r_mask & (r_mask - 1'b1);
    assign out_free  = !r_ovalid || i_m_axis_tready;

    function automatic logic [63:0] pick(input mh64v1_pkg::t_reg sel,
                                         input logic [63:0] v0, input logic [63:0] v1,
                                         input logic [63:0] v2, input logic [63:0] v3,
                                         input logic [63:0] h, input logic [63:0] a,
                                         input logic [63:0] b, input logic [63:0] t,
                                         input logic [63:0] d, input logic [63:0] w0,
                                         input logic [63:0] w1, input logic [63:0] w2,
                                         input logic wsel, input logic [31:0] sd,
                                         input logic [63:0] ln, input logic [1:0] k);
        case (sel)
            mh64v1_pkg::R_V0:   pick = v0;
            mh64v1_pkg::R_V1:   pick = v1;
            mh64v1_pkg::R_V2:   pick = v2;
            mh64v1_pkg::R_V3:   pick = v3;
            mh64v1_pkg::R_H:    pick = h;
            mh64v1_pkg::R_A:    pick = a;
            mh64v1_pkg::R_B:    pick = b;
            mh64v1_pkg::R_T:    pick = t;
            mh64v1_pkg::R_DATA: pick = d;
            mh64v1_pkg::R_W0:   pick = w0;
            mh64v1_pkg::R_W1:   pick = w1;
            mh64v1_pkg::R_W2:   pick = w2;
            mh64v1_pkg::R_WT1:  pick = wsel ? w2 : w0;
            mh64v1_pkg::R_SEED: pick = {32'd0, sd};
            mh64v1_pkg::R_LEN:  pick = ln;
            mh64v1_pkg::R_KC:   pick = {32'd0, mh64v1_pkg::kconst(k)};
            mh64v1_pkg::R_P32:  pick = {32'd0, d[31:0]};
            mh64v1_pkg::R_P16:  pick = {48'd0, d[15:0]};
            mh64v1_pkg::R_P8:   pick = {56'd0, d[7:0]};
            default:            pick = 64'd0;
        endcase
    endfunction

    assign op_a = pick(cur.sa, r_v0, r_v1, r_v2, r_v3, r_h, r_a, r_b, r_t, r_data,
                       r_w0, r_w1, r_w2, r_wt1_sel, r_seed, r_len, cur.k);
    assign op_b = pick(cur.sb, r_v0, r_v1, r_v2, r_v3, r_h, r_a, r_b, r_t, r_data,
                       r_w0, r_w1, r_w2, r_wt1_sel, r_seed, r_len, cur.k);

    mh64v1_alu u_alu (
        .i_clk    (i_clk),
        .i_uop    (cur),
        .i_mul_hi (r_mul_hi),
        .i_a      (op_a),
        .i_b      (op_b),
        .o_res    (res)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (acc && (n_mask != '0)) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (step_done && cur.fin && (rest == '0)) begin
                    n_state = r_last ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_seed   <= mh64v1_pkg::SEED_RESET;
            r_bcnt   <= 2'd0;
            r_bs     <= 1'b0;
            r_start  <= 1'b1;
            r_mask   <= '0;
            r_pc     <= '0;
            r_mul_hi <= 1'b0;
            r_ovalid <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_seed <= i_cfg_wr_data;
            end
            if (r_state == ST_EMIT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (acc) begin
                        r_start  <= 1'b0;
                        r_bcnt   <= n_bcnt;
                        r_bs     <= n_bs;
                        r_last   <= i_s_axis_tlast;
                        r_mask   <= n_mask;
                        r_pc     <= mh64v1_pkg::seg_start(mh64v1_pkg::first_seg(n_mask));
                        r_mul_hi <= 1'b0;
                    end
                end
                ST_RUN: begin
                    if (cur.op == mh64v1_pkg::OP_MUL) begin
                        r_mul_hi <= !r_mul_hi;
                    end
                    if (step_done) begin
                        if (cur.fin) begin
                            r_mask <= rest;
                            r_pc   <= mh64v1_pkg::seg_start(mh64v1_pkg::first_seg(rest));
                        end else begin
                            r_pc <= r_pc + 1'b1;
                        end
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_start  <= 1'b1;
                        r_bcnt   <= 2'd0;
                        r_bs     <= 1'b0;
                    end
                end
                default: r_mask <= '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_EMIT && out_free) begin
            r_odata <= r_h;
        end
        if (acc) begin
            r_data    <= in_data;
            r_wt1_sel <= (n_cnt == 2'd3);
            if (r_start) begin
                r_len <= in_len;
            end
            if (full && !lane) begin
                case (bc_eff)
                    2'd0:    r_w0 <= in_data;
                    2'd1:    r_w1 <= in_data;
                    default: r_w2 <= in_data;
                endcase
            end
        end else if (r_state == ST_RUN && step_done) begin
            case (cur.dst)
                mh64v1_pkg::R_V0:   r_v0   <= res;
                mh64v1_pkg::R_V1:   r_v1   <= res;
                mh64v1_pkg::R_V2:   r_v2   <= res;
                mh64v1_pkg::R_V3:   r_v3   <= res;
                mh64v1_pkg::R_H:    r_h    <= res;
                mh64v1_pkg::R_A:    r_a    <= res;
                mh64v1_pkg::R_B:    r_b    <= res;
                mh64v1_pkg::R_T:    r_t    <= res;
                mh64v1_pkg::R_DATA: r_data <= res;
                default:            r_t    <= r_t;
            endcase
        end
    end
endmodule
`default_nettype wire
